>>> sv/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

	// Request kinds
	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_PUT = 1'b1;

	// Fixed read values
	localparam logic signed [31:0] READ_MISS = 32'hFFFF_FFFF;
	localparam logic signed [31:0] READ_PUT  = 32'h0000_0000;

	// Configuration register map
	localparam int          PADDR_W       = 3;
	localparam logic        ADDR_CAPACITY = 1'b0;  // word index, paddr[2]
	localparam logic [3:0]  CAPACITY_RST  = 4'd8;

	typedef struct packed {
		logic               req_type;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
		logic               evicted;
	} rsp_t;

	// Sequencer commands to the datapath
	typedef struct packed {
		logic capture;
		logic compare;
		logic update;
		logic load;
	} cmd_t;

	// Datapath status back to the sequencer
	typedef struct packed {
		logic out_busy;
	} status_t;

endpackage

`default_nettype wire

>>> sv/lkvc_ctrl.sv
// Sequencer for the LRU key/value cache: capture, compare, update, result.
`timescale 1ns / 1ps
`default_nettype none

module lkvc_ctrl
	import lkvc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_stall,
	input  wire status_t status,
	output cmd_t         cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_UPDATE,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   stall_q;
	logic   compare_q;
	logic   update_q;

	// Capture and load are decided in the cycle they happen
	assign cmd.capture = (state_q == S_IDLE) && req_valid;
	assign cmd.compare = compare_q;
	assign cmd.update  = update_q;
	assign cmd.load    = (state_q == S_RESULT) && !status.out_busy;
	assign req_stall   = stall_q;

	// State and registered commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			stall_q   <= 1'b0;
			compare_q <= 1'b0;
			update_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q   <= S_MATCH;
						stall_q   <= 1'b1;
						compare_q <= 1'b1;
					end
				end
				S_MATCH: begin
					state_q   <= S_UPDATE;
					compare_q <= 1'b0;
					update_q  <= 1'b1;
				end
				S_UPDATE: begin
					state_q  <= S_RESULT;
					update_q <= 1'b0;
				end
				S_RESULT: begin
					// hold while the previous result is still stalled
					if (!status.out_busy) begin
						state_q <= S_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q   <= S_IDLE;
					stall_q   <= 1'b0;
					compare_q <= 1'b0;
					update_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/lkvc_dp.sv
// Datapath for the LRU key/value cache: key CAM, ranks, value memory, result register.
`timescale 1ns / 1ps
`default_nettype none

module lkvc_dp
	import lkvc_pkg::*;
#(
	parameter int N = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cmd_t       cmd,
	output status_t         status,
	input  wire req_t       req,
	input  wire logic [3:0] capacity,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output rsp_t            rsp
);

	localparam int IW = (N > 1) ? $clog2(N) : 1;
	localparam int OW = $clog2(N + 1);
	localparam int EW = (OW > 4) ? OW : 4;

	req_t                  req_q;
	logic signed [31:0]    key_q [N];
	logic signed [31:0]    value_mem [N];
	logic [N-1:0]          valid_q;
	logic [IW-1:0]         rank_q [N];
	logic [OW-1:0]         occ_q;
	logic [N-1:0]          match_q;
	logic [N-1:0]          victim_q;
	logic signed [31:0]    rdata_q;
	logic                  evict_q;
	rsp_t                  out_q;
	logic                  out_valid_q;

	logic                  hit_any;
	logic [IW-1:0]         hit_idx;
	logic [IW-1:0]         old_rank;
	logic [EW-1:0]         cap_ext;
	logic [EW-1:0]         ecap;
	logic                  full;
	logic [N-1:0]          valid_nxt;
	logic [N-1:0]          free_oh;
	logic [IW-1:0]         free_idx;
	logic                  is_put;

	assign is_put          = (req_q.req_type == REQ_PUT);
	assign status.out_busy = out_valid_q && rsp_stall;
	assign rsp_valid       = out_valid_q;
	assign rsp             = out_q;

	// Effective capacity: zero reads as one, large values saturate
	always_comb begin
		cap_ext = EW'(capacity);
		if (cap_ext == '0) begin
			ecap = EW'(1);
		end else if (cap_ext > EW'(N)) begin
			ecap = EW'(N);
		end else begin
			ecap = cap_ext;
		end
	end

	// Hit slot, its rank, victim removal and the lowest free slot
	always_comb begin
		hit_any  = |match_q;
		hit_idx  = '0;
		old_rank = '0;
		free_idx = '0;
		for (int i = 0; i < N; i++) begin
			if (match_q[i]) begin
				hit_idx  = hit_idx | IW'(i);
				old_rank = old_rank | rank_q[i];
			end
		end
		full      = (EW'(occ_q) >= ecap);
		valid_nxt = valid_q & ~(full ? victim_q : '0);
		free_oh   = ~valid_nxt & (valid_nxt + N'(1));
		for (int i = 0; i < N; i++) begin
			if (free_oh[i]) begin
				free_idx = free_idx | IW'(i);
			end
		end
	end

	// Request capture, key compare, victim pick (highest rank is occ-1)
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.compare) begin
			for (int i = 0; i < N; i++) begin
				match_q[i]  <= valid_q[i] && (key_q[i] == req_q.key);
				victim_q[i] <= valid_q[i] && (OW'(rank_q[i]) == OW'(occ_q - 1'b1));
			end
		end
		if (cmd.update) begin
			evict_q <= is_put && !hit_any && full;
		end
	end

	// Keys are written only into the slot picked for a new entry
	always_ff @(posedge clk) begin
		if (cmd.update && is_put && !hit_any) begin
			for (int i = 0; i < N; i++) begin
				if (free_oh[i]) begin
					key_q[i] <= req_q.key;
				end
			end
		end
	end

	// Value memory: one write port, registered read at the hit slot
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			rdata_q <= value_mem[hit_idx];
			if (is_put) begin
				value_mem[hit_any ? hit_idx : free_idx] <= req_q.value;
			end
		end
	end

	// Valid bits, recency ranks and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < N; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.update) begin
			if (hit_any) begin
				// touch: entries newer than the hit age by one
				for (int i = 0; i < N; i++) begin
					if (match_q[i]) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (rank_q[i] < old_rank)) begin
						rank_q[i] <= IW'(rank_q[i] + 1'b1);
					end
				end
			end else if (is_put) begin
				// insert as newest, after an optional eviction
				for (int i = 0; i < N; i++) begin
					if (free_oh[i]) begin
						rank_q[i] <= '0;
					end else if (valid_nxt[i]) begin
						rank_q[i] <= IW'(rank_q[i] + 1'b1);
					end
				end
				valid_q <= valid_nxt | free_oh;
				if (!full) begin
					occ_q <= OW'(occ_q + 1'b1);
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q.hit     <= hit_any;
			out_q.evicted <= evict_q;
			if (is_put) begin
				out_q.read_value <= READ_PUT;
			end else if (hit_any) begin
				out_q.read_value <= rdata_q;
			end else begin
				out_q.read_value <= READ_MISS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> sv/lru_key_value_cache.sv
// Top level of the fully associative LRU key/value cache.
//
//  Port group   Dir   Handshake             Carries
//  req          in    req_valid/req_stall   req_type, key, value
//  rsp          out   rsp_valid/rsp_stall   hit, read_value, evicted
//  APB          in    psel/penable/pready   capacity register at 0x0
//
// Each request runs through capture, parallel key compare, state update
// with value memory access and result register load; the sequencer takes the
// next request in the cycle after the result is loaded.
// Reset clears valid bits, ranks and occupancy at once and sets capacity to 8.
// A stalled result waits in the output register while the next request runs;
// that request then holds in its load step until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache
	import lkvc_pkg::*;
#(
	parameter int MAX_ENTRIES = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire req_t               req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output rsp_t                    rsp,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	cmd_t       cmd;
	status_t    status;
	logic [3:0] capacity_q;
	logic       cfg_wr;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RST;
		end else if (cfg_wr && (paddr[2] == ADDR_CAPACITY)) begin
			capacity_q <= pwdata[3:0];
		end
	end

	assign prdata = (paddr[2] == ADDR_CAPACITY) ? {28'd0, capacity_q} : 32'd0;

	lkvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	lkvc_dp #(
		.N (MAX_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.req       (req),
		.capacity  (capacity_q),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// A taken request blocks the port until its result is loaded
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request port open right after a request was taken");

	// A new result only appears out of a busy sequencer
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared without a request in flight");

	// Eviction only happens on a put of a new key
	a_evict_is_put_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.evicted) |-> (!rsp.hit && (rsp.read_value == READ_PUT)))
		else $error("eviction reported on a hit or on a get");

endmodule

`default_nettype wire
